### src/gle_pkg.sv
// gle_pkg: shared constants and helpers of the lzw pixel encoder
// depends on nothing; used by gle_hash, the core and tb_top
package gle_pkg;

   localparam int CODE_W  = 12;
   localparam int KEY_W   = 20;
   localparam int EPOCH_W = 8;
   localparam int NEXT_W  = 13;
   localparam int CNT_W   = 5;
   localparam int BUF_W   = 20;

   localparam logic [CODE_W-1:0]  CODE_CLEAR      = 12'd256;
   localparam logic [CODE_W-1:0]  CODE_END        = 12'd257;
   localparam logic [NEXT_W-1:0]  CODE_FIRST_FREE = 13'd258;
   localparam logic [3:0]         WIDTH_MIN       = 4'd9;
   localparam logic [3:0]         WIDTH_MAX       = 4'd12;
   localparam logic [31:0]        HASH_MUL        = 32'd2654435761;

   typedef logic [KEY_W-1:0]   key_type;
   typedef logic [CODE_W-1:0]  code_type;
   typedef logic [EPOCH_W-1:0] epoch_type;

   // one dictionary entry: epoch tag, key, code
   typedef struct packed {
      epoch_type epoch;
      key_type   key;
      code_type  code;
   } entry_type;

   // rgb332 palette index of a 0xRRGGBB pixel
   function automatic logic [7:0] rgb332(input logic [23:0] p);
      rgb332 = {p[23:21], p[15:13], p[7:6]};
   endfunction

endpackage

### src/gle_if.sv
// gle_if: valid/ready channels of the lzw pixel encoder
// no dependencies
interface gle_req_if;
   logic        valid;
   logic        ready;
   logic [23:0] pixel_rgb;
   logic        first_pixel;
   logic        last_pixel;
   modport source (output valid, pixel_rgb, first_pixel, last_pixel, input ready);
   modport sink   (input valid, pixel_rgb, first_pixel, last_pixel, output ready);
endinterface

interface gle_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       frame_done;
   modport source (output valid, out_byte, run_last, frame_done, input ready);
   modport sink   (input valid, out_byte, run_last, frame_done, output ready);
endinterface

### src/gle_ram.sv
// gle_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
module gle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

### src/gle_hash.sv
// gle_hash: two-stage multiplicative hash of a dictionary key to a slot
// depends on gle_pkg
module gle_hash #(
   parameter int TABLE_ENTRIES = 8192
) (
   input  logic                             clock,
   input  gle_pkg::key_type                 key,
   output logic [$clog2(TABLE_ENTRIES)-1:0] slot
);
   import gle_pkg::*;

   localparam int SLOT_W = $clog2(TABLE_ENTRIES);
   localparam int MUL2_W = 32 + SLOT_W + 1;

   logic [51:0]       prod1;
   logic [31:0]       h_ff;
   logic [MUL2_W-1:0] prod2;

   // stage one: key times golden-ratio constant, low word
   assign prod1 = 52'(key) * 52'(HASH_MUL);

   // stage two: scale hash to table size
   assign prod2 = MUL2_W'(h_ff) * MUL2_W'(TABLE_ENTRIES);

   always_ff @(posedge clock) begin
      h_ff <= prod1[31:0];
      slot <= prod2[32 +: SLOT_W];
   end
endmodule

### src/gif_lzw_pixel_encoder_core.sv
// gif_lzw_pixel_encoder_core: lzw encoder of rgb332 pixels with hashed dictionary
// depends on gle_pkg, gle_if, gle_ram, gle_hash
//
//  channel   dir  payload                              handshake
//  req_ch    in   pixel_rgb, first_pixel, last_pixel   valid/ready
//  rsp_ch    out  out_byte, run_last, frame_done       valid/ready
//
// one pixel at a time: the hash states HASH1 to HASH3, then RD and CMP for each probe of the
// dictionary ram (registered read), plus PUT for each emitted code and EMIT for each byte.
// wipes bump an epoch tag; when the tag wraps, and after reset, a clearing pass
// writes every entry and no pixel is taken meanwhile.
// a stalled rsp_ch holds the sequencer once the byte stage and hold byte are full.
module gif_lzw_pixel_encoder_core #(
   parameter int TABLE_ENTRIES = 8192,
   parameter int MAX_CODES     = 4096
) (
   input  logic           clock,
   input  logic           reset,
   gle_req_if.sink        req_ch,
   gle_rsp_if.source      rsp_ch
);
   import gle_pkg::*;

   localparam int SLOT_W  = $clog2(TABLE_ENTRIES);
   localparam int PROBE_W = SLOT_W + 1;
   localparam int ENTRY_W = $bits(entry_type);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_CLEAR   = 4'd1;
   localparam logic [3:0] S_HASH1   = 4'd2;
   localparam logic [3:0] S_HASH2   = 4'd3;
   localparam logic [3:0] S_HASH3   = 4'd4;
   localparam logic [3:0] S_RD      = 4'd5;
   localparam logic [3:0] S_CMP     = 4'd6;
   localparam logic [3:0] S_PUT     = 4'd7;
   localparam logic [3:0] S_EMIT    = 4'd8;
   localparam logic [3:0] S_MISS2   = 4'd9;
   localparam logic [3:0] S_CLRDONE = 4'd10;
   localparam logic [3:0] S_LASTCHK = 4'd11;
   localparam logic [3:0] S_L2      = 4'd12;
   localparam logic [3:0] S_L3      = 4'd13;
   localparam logic [3:0] S_FIN     = 4'd14;

   logic [3:0]        state_ff, state_in;
   logic [3:0]        ret_ff, ret_in;
   code_type          put_ff, put_in;
   logic [7:0]        sym_ff, sym_in;
   logic              last_ff, last_in;
   code_type          prefix_ff, prefix_in;
   logic [NEXT_W-1:0] next_ff, next_in;
   logic [3:0]        width_ff, width_in;
   logic [BUF_W-1:0]  buf_ff, buf_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   epoch_type         epoch_ff, epoch_in;
   logic              wipe_ff, wipe_in;
   logic              space_ff, space_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [PROBE_W-1:0] probe_ff, probe_in;
   logic [SLOT_W-1:0] clr_ff, clr_in;
   logic [7:0]        hold_ff, hold_in;
   logic              hold_v_ff, hold_v_in;
   logic              out_v_ff, out_v_in;
   logic [7:0]        out_byte_ff, out_byte_in;
   logic              out_last_ff, out_last_in;
   logic              out_done_ff, out_done_in;

   logic              slot_free;
   logic              emit_go;
   key_type           key;
   logic [SLOT_W-1:0] hash_slot;
   logic              ram_we;
   logic [SLOT_W-1:0] ram_waddr;
   entry_type         ram_wdata;
   entry_type         ram_rdata;
   logic [ENTRY_W-1:0] ram_rraw;
   logic [NEXT_W-1:0] next_inc;
   logic [NEXT_W-1:0] width_pow;
   epoch_type         epoch_inc;
   logic [BUF_W-1:0]  put_shift;

   assign key       = {prefix_ff, sym_ff};
   assign slot_free = !out_v_ff || rsp_ch.ready;
   assign emit_go   = !hold_v_ff || slot_free;
   assign next_inc  = next_ff + NEXT_W'(1);
   assign width_pow = NEXT_W'(1) << width_ff;
   assign epoch_inc = epoch_ff + EPOCH_W'(1);
   assign put_shift = BUF_W'(put_ff) << cnt_ff;
   assign ram_rdata = entry_type'(ram_rraw);

   assign req_ch.ready      = (state_ff == S_IDLE);
   assign rsp_ch.valid      = out_v_ff;
   assign rsp_ch.out_byte   = out_byte_ff;
   assign rsp_ch.run_last   = out_last_ff;
   assign rsp_ch.frame_done = out_done_ff;

   gle_hash #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_hash (
      .clock (clock),
      .key   (key),
      .slot  (hash_slot)
   );

   gle_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_dict (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (slot_ff),
      .rdata (ram_rraw)
   );

   // dictionary write port: clearing pass or new entry on a miss
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = slot_ff;
      ram_wdata = '{epoch: epoch_ff, key: key, code: next_ff[CODE_W-1:0]};
      if (state_ff == S_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_ff;
         ram_wdata = '0;
      end else if (state_ff == S_MISS2 && next_ff < NEXT_W'(MAX_CODES)) begin
         ram_we = space_ff;
      end
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      ret_in      = ret_ff;
      put_in      = put_ff;
      sym_in      = sym_ff;
      last_in     = last_ff;
      prefix_in   = prefix_ff;
      next_in     = next_ff;
      width_in    = width_ff;
      buf_in      = buf_ff;
      cnt_in      = cnt_ff;
      epoch_in    = epoch_ff;
      wipe_in     = wipe_ff;
      space_in    = space_ff;
      slot_in     = slot_ff;
      probe_in    = probe_ff;
      clr_in      = clr_ff;
      hold_in     = hold_ff;
      hold_v_in   = hold_v_ff;
      out_v_in    = out_v_ff && !rsp_ch.ready;
      out_byte_in = out_byte_ff;
      out_last_in = out_last_ff;
      out_done_in = out_done_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               sym_in  = rgb332(req_ch.pixel_rgb);
               last_in = req_ch.last_pixel;
               if (req_ch.first_pixel) begin
                  next_in   = CODE_FIRST_FREE;
                  width_in  = WIDTH_MIN;
                  buf_in    = '0;
                  cnt_in    = '0;
                  wipe_in   = 1'b1;
                  prefix_in = code_type'(rgb332(req_ch.pixel_rgb));
                  put_in    = CODE_CLEAR;
                  ret_in    = S_LASTCHK;
                  state_in  = S_PUT;
               end else begin
                  state_in = S_HASH1;
               end
            end
         end
         S_CLEAR: begin
            clr_in = clr_ff + SLOT_W'(1);
            if (clr_ff == SLOT_W'(TABLE_ENTRIES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_HASH1: state_in = S_HASH2;
         S_HASH2: state_in = S_HASH3;
         S_HASH3: begin
            slot_in  = hash_slot;
            probe_in = '0;
            state_in = S_RD;
         end
         S_RD: state_in = S_CMP;
         // probe compare: empty slot, hit, or step to the next slot until the whole table is probed
         S_CMP: begin
            if (ram_rdata.epoch != epoch_ff) begin
               space_in = 1'b1;
               put_in   = prefix_ff;
               ret_in   = S_MISS2;
               state_in = S_PUT;
            end else if (ram_rdata.key == key) begin
               prefix_in = ram_rdata.code;
               state_in  = S_LASTCHK;
            end else begin
               slot_in  = (slot_ff == SLOT_W'(TABLE_ENTRIES - 1)) ? '0
                                                                 : slot_ff + SLOT_W'(1);
               probe_in = probe_ff + PROBE_W'(1);
               if (probe_ff + PROBE_W'(1) == PROBE_W'(TABLE_ENTRIES)) begin
                  space_in = 1'b0;
                  put_in   = prefix_ff;
                  ret_in   = S_MISS2;
                  state_in = S_PUT;
               end else begin
                  state_in = S_RD;
               end
            end
         end
         // append a code to the bit buffer
         S_PUT: begin
            buf_in   = buf_ff | put_shift;
            cnt_in   = cnt_ff + CNT_W'(width_ff);
            state_in = S_EMIT;
         end
         // drain whole bytes into the hold byte
         S_EMIT: begin
            if (cnt_ff >= CNT_W'(8)) begin
               if (emit_go) begin
                  if (hold_v_ff) begin
                     out_v_in    = 1'b1;
                     out_byte_in = hold_ff;
                     out_last_in = 1'b0;
                     out_done_in = 1'b0;
                  end
                  hold_in   = buf_ff[7:0];
                  hold_v_in = 1'b1;
                  buf_in    = buf_ff >> 8;
                  cnt_in    = cnt_ff - CNT_W'(8);
               end
            end else begin
               state_in = ret_ff;
            end
         end
         S_MISS2: begin
            if (next_ff < NEXT_W'(MAX_CODES)) begin
               next_in = next_inc;
               if (next_inc > width_pow && width_ff < WIDTH_MAX) begin
                  width_in = width_ff + 4'd1;
               end
               prefix_in = code_type'(sym_ff);
               state_in  = S_LASTCHK;
            end else begin
               put_in   = CODE_CLEAR;
               ret_in   = S_CLRDONE;
               state_in = S_PUT;
            end
         end
         S_CLRDONE: begin
            next_in   = CODE_FIRST_FREE;
            width_in  = WIDTH_MIN;
            wipe_in   = 1'b1;
            prefix_in = code_type'(sym_ff);
            state_in  = S_LASTCHK;
         end
         S_LASTCHK: begin
            if (last_ff) begin
               put_in   = prefix_ff;
               ret_in   = S_L2;
               state_in = S_PUT;
            end else begin
               state_in = S_FIN;
            end
         end
         S_L2: begin
            if (next_ff == width_pow && width_ff < WIDTH_MAX) begin
               width_in = width_ff + 4'd1;
            end
            put_in   = CODE_END;
            ret_in   = S_L3;
            state_in = S_PUT;
         end
         // pad the tail byte, return to the reset values and request a wipe
         S_L3: begin
            if (cnt_ff == '0 || emit_go) begin
               if (cnt_ff != '0) begin
                  if (hold_v_ff) begin
                     out_v_in    = 1'b1;
                     out_byte_in = hold_ff;
                     out_last_in = 1'b0;
                     out_done_in = 1'b0;
                  end
                  hold_in   = buf_ff[7:0];
                  hold_v_in = 1'b1;
               end
               prefix_in = '0;
               next_in   = CODE_FIRST_FREE;
               width_in  = WIDTH_MIN;
               buf_in    = '0;
               cnt_in    = '0;
               wipe_in   = 1'b1;
               state_in  = S_FIN;
            end
         end
         // last byte of the item, then epoch bump if a wipe is pending and a clearing pass when the epoch wraps
         S_FIN: begin
            if (!hold_v_ff || slot_free) begin
               if (hold_v_ff) begin
                  out_v_in    = 1'b1;
                  out_byte_in = hold_ff;
                  out_last_in = 1'b1;
                  out_done_in = last_ff;
                  hold_v_in   = 1'b0;
               end
               state_in = S_IDLE;
               if (wipe_ff) begin
                  wipe_in  = 1'b0;
                  epoch_in = epoch_inc;
                  if (epoch_inc == '0) begin
                     epoch_in = EPOCH_W'(1);
                     clr_in   = '0;
                     state_in = S_CLEAR;
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         epoch_ff  <= EPOCH_W'(1);
         prefix_ff <= '0;
         next_ff   <= CODE_FIRST_FREE;
         width_ff  <= WIDTH_MIN;
         buf_ff    <= '0;
         cnt_ff    <= '0;
         wipe_ff   <= 1'b0;
         hold_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         epoch_ff  <= epoch_in;
         prefix_ff <= prefix_in;
         next_ff   <= next_in;
         width_ff  <= width_in;
         buf_ff    <= buf_in;
         cnt_ff    <= cnt_in;
         wipe_ff   <= wipe_in;
         hold_v_ff <= hold_v_in;
         out_v_ff  <= out_v_in;
      end
   end

   // payload and scratch registers
   always_ff @(posedge clock) begin
      ret_ff      <= ret_in;
      put_ff      <= put_in;
      sym_ff      <= sym_in;
      last_ff     <= last_in;
      space_ff    <= space_in;
      slot_ff     <= slot_in;
      probe_ff    <= probe_in;
      hold_ff     <= hold_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      out_done_ff <= out_done_in;
   end

   // no pixel taken while the clearing pass runs
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !req_ch.ready)
      else $error("pixel taken during clearing pass");

   // bit buffer holds less than a byte and the hold byte is empty between items
   a_idle_partial: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> (cnt_ff < CNT_W'(8) && !hold_v_ff))
      else $error("leftover bits or hold byte at idle");

   // code width stays in range
   a_width_range: assert property (@(posedge clock) disable iff (reset)
      width_ff >= WIDTH_MIN && width_ff <= WIDTH_MAX)
      else $error("code width out of range");

   // frame end byte always closes its item
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.frame_done |-> rsp_ch.run_last)
      else $error("frame_done without run_last");

endmodule

### tb/sv/tb_gle_if.sv
// tb_gle_if: item types of the pixel and byte transfers seen by the testbench
// depends on nothing; used by tb_top
`timescale 1ns / 100ps
package tb_gle_types;
   typedef struct packed {
      logic [23:0] pixel_rgb;
      logic        first_pixel;
      logic        last_pixel;
   } pixel_item_type;
   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       frame_done;
   } byte_item_type;
endpackage

### tb/sv/tb_top.sv
// tb_top: self-checking testbench of the lzw pixel encoder core
// depends on gle_pkg, gle_if, tb_gle_types and the core; predicts bytes in-line
`timescale 1ns / 100ps
module tb_top;
   import gle_pkg::*;
   import tb_gle_types::*;

   localparam int TBL   = 8192;
   localparam int MAXC  = 4096;

   logic clock = 1'b0;
   logic reset = 1'b1;

   gle_req_if req_ch ();
   gle_rsp_if rsp_ch ();

   gif_lzw_pixel_encoder_core #(.TABLE_ENTRIES(TBL), .MAX_CODES(MAXC)) i_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   // clock generation
   always #6 clock = ~clock;

   // predictor state of the encoder
   logic [20:0] enc_keys [TBL];
   logic [11:0] enc_codes [TBL];
   logic [11:0] enc_prefix;
   logic [12:0] enc_next;
   logic [3:0]  enc_width;
   logic [31:0] enc_buf;
   logic [4:0]  enc_cnt;

   pixel_item_type pending_pixels [$];
   byte_item_type  expected_bytes [$];
   byte_item_type  step_bytes [$];
   int          mismatch_count = 0;
   int          byte_count = 0;
   int          frame_count = 0;
   int          pixel_count = 0;
   bit          quiet_idle = 1'b0;
   bit          hold_sender = 1'b0;

   function automatic void wipe_dict();
      for (int i = 0; i < TBL; i++) enc_keys[i] = '0;
      enc_next  = CODE_FIRST_FREE;
      enc_width = WIDTH_MIN;
   endfunction

   function automatic void reset_encoder();
      wipe_dict();
      enc_prefix = '0;
      enc_buf    = '0;
      enc_cnt    = '0;
   endfunction

   function automatic void pack_code(input logic [11:0] value, input logic [3:0] width);
      byte_item_type b;
      enc_buf = enc_buf | (32'(value) << enc_cnt);
      enc_cnt = enc_cnt + 5'(width);
      while (enc_cnt >= 8) begin
         b = '{enc_buf[7:0], 1'b0, 1'b0};
         step_bytes.push_back(b);
         enc_buf = enc_buf >> 8;
         enc_cnt = enc_cnt - 5'd8;
      end
   endfunction

   function automatic void extend_string(input logic [7:0] sym);
      logic [19:0] key;
      logic [31:0] h;
      logic [63:0] prod;
      int slot;
      bit hit;
      bit space;
      key  = {enc_prefix, sym};
      h    = 32'(key) * HASH_MUL;
      prod = 64'(h) * 64'(TBL);
      slot = int'(prod >> 32);
      hit = 0;
      space = 0;
      for (int n = 0; n < TBL; n++) begin
         if (!enc_keys[slot][20]) begin
            space = 1;
            break;
         end
         if (enc_keys[slot][19:0] == key) begin
            hit = 1;
            break;
         end
         slot = (slot + 1 == TBL) ? 0 : slot + 1;
      end
      if (hit) begin
         enc_prefix = enc_codes[slot];
         return;
      end
      pack_code(enc_prefix, enc_width);
      if (enc_next < MAXC) begin
         if (space) begin
            enc_keys[slot]  = {1'b1, key};
            enc_codes[slot] = enc_next[11:0];
         end
         enc_next = enc_next + 13'd1;
         if (32'(enc_next) > (32'd1 << enc_width) && enc_width < WIDTH_MAX)
            enc_width = enc_width + 4'd1;
      end else begin
         pack_code(CODE_CLEAR, enc_width);
         wipe_dict();
      end
      enc_prefix = {4'd0, sym};
   endfunction

   // expected bytes of one accepted pixel
   function automatic void encode_pixel(input pixel_item_type p);
      logic [7:0] sym;
      byte_item_type b;
      sym = {p.pixel_rgb[23:21], p.pixel_rgb[15:13], p.pixel_rgb[7:6]};
      step_bytes.delete();
      if (p.first_pixel) begin
         wipe_dict();
         enc_buf = '0;
         enc_cnt = '0;
         pack_code(CODE_CLEAR, enc_width);
         enc_prefix = {4'd0, sym};
      end else begin
         extend_string(sym);
      end
      if (p.last_pixel) begin
         pack_code(enc_prefix, enc_width);
         if (32'(enc_next) == (32'd1 << enc_width) && enc_width < WIDTH_MAX)
            enc_width = enc_width + 4'd1;
         pack_code(CODE_END, enc_width);
         if (enc_cnt != 0) begin
            b = '{enc_buf[7:0], 1'b0, 1'b0};
            step_bytes.push_back(b);
         end
         step_bytes[step_bytes.size()-1].frame_done = 1'b1;
         reset_encoder();
      end
      if (step_bytes.size() > 0) step_bytes[step_bytes.size()-1].run_last = 1'b1;
      foreach (step_bytes[i]) expected_bytes.push_back(step_bytes[i]);
   endfunction

   function automatic logic [23:0] rand_pixel();
      return 24'($urandom);
   endfunction

   function automatic logic [23:0] pixel_of_index(input logic [7:0] s);
      return {s[7:5], 5'($urandom), s[4:2], 5'($urandom), s[1:0], 6'($urandom)};
   endfunction

   task automatic queue_pixel(input logic [23:0] rgb, input bit first, input bit last);
      pending_pixels.push_back('{rgb, first, last});
   endtask

   // driver: presents pending pixels, with random idle cycles
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid       <= 1'b0;
         req_ch.pixel_rgb   <= '0;
         req_ch.first_pixel <= 1'b0;
         req_ch.last_pixel  <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (pending_pixels.size() > 0 && !hold_sender
             && (quiet_idle || $urandom_range(99) >= 32)) begin
            req_ch.valid       <= 1'b1;
            req_ch.pixel_rgb   <= pending_pixels[0].pixel_rgb;
            req_ch.first_pixel <= pending_pixels[0].first_pixel;
            req_ch.last_pixel  <= pending_pixels[0].last_pixel;
            void'(pending_pixels.pop_front());
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // pixel transfer feeds the predictor
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         encode_pixel('{req_ch.pixel_rgb, req_ch.first_pixel, req_ch.last_pixel});
         pixel_count++;
      end
   end

   // monitor: random backpressure and byte comparison
   always @(posedge clock) begin
      byte_item_type exp_b;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= quiet_idle || ($urandom_range(99) >= 32);
         if (rsp_ch.valid && rsp_ch.ready) begin
            byte_count++;
            if (expected_bytes.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected byte %02h run_last %0b frame_done %0b",
                           rsp_ch.out_byte, rsp_ch.run_last, rsp_ch.frame_done);
            end else begin
               exp_b = expected_bytes.pop_front();
               if (exp_b.frame_done) frame_count++;
               if (rsp_ch.out_byte !== exp_b.out_byte || rsp_ch.run_last !== exp_b.run_last
                   || rsp_ch.frame_done !== exp_b.frame_done) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("byte mismatch: expected %02h/%0b/%0b actual %02h/%0b/%0b",
                              exp_b.out_byte, exp_b.run_last, exp_b.frame_done,
                              rsp_ch.out_byte, rsp_ch.run_last, rsp_ch.frame_done);
               end
            end
         end
      end
   end

   // timeout
   initial begin
      #15ms;
      $display("Simulation FAILED");
      $finish;
   end

   // stimulus and end of run
   initial begin
      int n;
      logic [7:0] motif [4];
      reset_encoder();
      for (int i = 0; i < TBL; i++) enc_codes[i] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: pixels with no open frame, field extremes, one-pixel frame
      queue_pixel(24'h000000, 0, 0);
      queue_pixel(24'hFFFFFF, 0, 0);
      queue_pixel(24'hFFFFFF, 0, 1);
      queue_pixel(24'hE0E0C0, 1, 1);
      queue_pixel(24'h123456, 1, 0);
      for (int i = 0; i < 10; i++) queue_pixel(24'h1F1F3F, 0, 0);
      queue_pixel(24'hA5A5A5, 0, 0);
      queue_pixel(24'h5A5A5A, 0, 1);
      queue_pixel(24'h000000, 0, 1);
      // clear frame in the middle of a run
      queue_pixel(24'h808080, 0, 0);
      queue_pixel(24'h7F7F7F, 1, 0);
      queue_pixel(24'h7F7F7F, 0, 1);

      // pause until every expected byte has come
      wait (pending_pixels.size() == 0 && !req_ch.valid);
      hold_sender = 1'b1;
      wait (expected_bytes.size() == 0);
      @(posedge clock);
      hold_sender = 1'b0;

      // random frames: repeating motifs for dictionary hits plus noise
      n = 0;
      while (n < 130) begin
         int len;
         len = $urandom_range(1, 40);
         if (len > 130 - n) len = 130 - n;
         foreach (motif[k]) motif[k] = 8'($urandom);
         for (int j = 0; j < len; j++) begin
            logic [23:0] px;
            px = ($urandom_range(9) < 7) ? pixel_of_index(motif[$urandom_range(3)])
                                          : rand_pixel();
            queue_pixel(px, j == 0 && $urandom_range(9) != 0, j == len - 1);
            n++;
         end
      end

      // long frame with no idling on either side
      wait (pending_pixels.size() == 0 && !req_ch.valid);
      wait (expected_bytes.size() == 0);
      quiet_idle = 1'b1;
      for (int j = 0; j < 60; j++)
         queue_pixel(pixel_of_index(8'($urandom_range(3))), j == 0, j == 59);
      wait (pending_pixels.size() == 0 && !req_ch.valid);
      wait (expected_bytes.size() == 0);
      quiet_idle = 1'b0;

      fork
         wait (expected_bytes.size() == 0);
         begin
            #5ms;
         end
      join_any
      disable fork;
      repeat (200) @(posedge clock);

      $display("%0d pixels in, %0d bytes checked, %0d frames closed, %0d mismatches",
               pixel_count, byte_count, frame_count, mismatch_count);
      if (mismatch_count == 0 && expected_bytes.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
